@@ sv/date_difference_julian_gregorian_unit_defines.svh @@
// Assertion macros for the date difference unit
`ifndef DATE_DIFFERENCE_JULIAN_GREGORIAN_UNIT_DEFINES_SVH
`define DATE_DIFFERENCE_JULIAN_GREGORIAN_UNIT_DEFINES_SVH

// expression must never hold outside reset
`define DDJG_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// antecedent implies consequent sequence
`define DDJG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

`endif

@@ sv/ddjg_pkg.sv @@
// Types, widths and month tables for the date difference unit
package ddjg_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DiffW  = 23;
  localparam int unsigned DayNumW = 23;

  localparam logic [YearW-1:0] ReformYear = 14'd1582;
  localparam logic [YearW-1:0] ReformYearM1 = 14'd1581;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthOct = 4'd10;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0] GapFirst = 5'd5;
  localparam logic [DayW-1:0] GapLast  = 5'd14;
  localparam logic [DayNumW-1:0] DaysPerYear = 23'd365;
  localparam logic [DayNumW-1:0] GapDays = 23'd10;
  localparam logic [12:0] GregOffset = 13'd2;

  // floor(a / 100) == (a * Recip100) >> Recip100Shift for all 14-bit a
  localparam int unsigned Recip100Shift = 19;
  localparam logic [26:0] Recip100 = 27'd5243;
  localparam logic [6:0] CenturyLast = 7'd99;

  typedef struct packed {
    logic [DayW-1:0]   first_day;
    logic [MonthW-1:0] first_month;
    logic [YearW-1:0]  first_year;
    logic [DayW-1:0]   second_day;
    logic [MonthW-1:0] second_month;
    logic [YearW-1:0]  second_year;
  } ddjg_in_t;

  typedef struct packed {
    logic signed [DiffW-1:0] day_difference;
    logic                    date_invalid;
  } ddjg_out_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] month_start(input logic [MonthW-1:0] m);
    logic [8:0] st;
    case (m)
      4'd1:    st = 9'd0;
      4'd2:    st = 9'd31;
      4'd3:    st = 9'd59;
      4'd4:    st = 9'd90;
      4'd5:    st = 9'd120;
      4'd6:    st = 9'd151;
      4'd7:    st = 9'd181;
      4'd8:    st = 9'd212;
      4'd9:    st = 9'd243;
      4'd10:   st = 9'd273;
      4'd11:   st = 9'd304;
      4'd12:   st = 9'd334;
      default: st = 9'd0;
    endcase
    return st;
  endfunction

endpackage

@@ sv/ddjg_day_num.sv @@
// Validity check and day number of one calendar date
module ddjg_day_num #(
  parameter int unsigned YEAR_MAX = 9999
) (
  input  logic [ddjg_pkg::DayW-1:0]    day_i,
  input  logic [ddjg_pkg::MonthW-1:0]  month_i,
  input  logic [ddjg_pkg::YearW-1:0]   year_i,
  output logic                         valid_o,
  output logic [ddjg_pkg::DayNumW-1:0] day_num_o
);
  import ddjg_pkg::*;

  logic [YearW-1:0]  yr_m1;
  logic [26:0]       prod;
  logic [7:0]        cent;
  logic [6:0]        cent_rem;
  logic [13:0]       cent_x100;
  logic              julian;
  logic              reform;
  logic              leap;
  logic [DayW-1:0]   len;
  logic              in_gap;
  logic              late;
  logic [12:0]       leap_term;

  assign yr_m1     = year_i - 14'd1;
  assign prod      = 27'(yr_m1) * Recip100;
  assign cent      = prod[Recip100Shift +: 8];
  assign cent_x100 = 14'(cent) * 14'd100;
  assign cent_rem  = 7'(yr_m1 - cent_x100);

  assign julian = year_i < ReformYear;
  assign reform = year_i == ReformYear;

  always_comb begin
    if (julian) begin
      leap = yr_m1[1:0] == 2'b11;
    end else if (reform) begin
      leap = 1'b0;
    end else begin
      leap = (yr_m1[1:0] == 2'b11) && ((cent_rem != CenturyLast) || (cent[1:0] == 2'b11));
    end
  end

  assign len    = month_len(month_i) + DayW'(month_i == MonthFeb && leap);
  assign in_gap = reform && month_i == MonthOct && day_i inside {[GapFirst:GapLast]};
  assign late   = reform && (month_i > MonthOct || (month_i == MonthOct && day_i > GapLast));

  assign valid_o = month_i != '0 && month_i <= MonthDec && year_i != '0
                   && 32'(year_i) <= YEAR_MAX && day_i != '0 && day_i <= len && !in_gap;

  always_comb begin
    if (yr_m1 <= ReformYearM1) begin
      leap_term = 13'(yr_m1 >> 2);
    end else begin
      leap_term = 13'(yr_m1 >> 2) - 13'(cent) + 13'(cent >> 2) + GregOffset;
    end
  end

  assign day_num_o = DayNumW'(yr_m1) * DaysPerYear + DayNumW'(leap_term)
                     + DayNumW'(month_start(month_i)) + DayNumW'(day_i)
                     + DayNumW'(month_i > MonthFeb && leap)
                     - (late ? GapDays : '0);

endmodule

@@ sv/date_difference_julian_gregorian_unit.sv @@
// Top level of the date difference unit: input register, day numbers, result register
//
//  channel  | ports                     | transfer
//  ---------+---------------------------+-------------------------------
//  command  | start_i, busy_o, item_i   | start_i high while busy_o low
//  result   | done_o, result_o          | done_o high for one cycle
//
// One pair of dates is taken every cycle; busy_o stays low.
// A pair passes through the input register, then through both day number units
// into the result register.
// Reset clears the valid flags only; the receiver cannot stall.
module date_difference_julian_gregorian_unit #(
  parameter int unsigned YEAR_MAX = 9999
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  ddjg_pkg::ddjg_in_t  item_i,
  output logic                done_o,
  output ddjg_pkg::ddjg_out_t result_o
);
  import ddjg_pkg::*;

  ddjg_in_t            in_q;
  logic                in_vld_q;
  ddjg_out_t           out_d, out_q;
  logic                done_q;
  logic                first_ok, second_ok;
  logic [DayNumW-1:0]  first_num, second_num;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
      done_q   <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= item_i;
    end
    if (in_vld_q) begin
      out_q <= out_d;
    end
  end

  ddjg_day_num #(.YEAR_MAX(YEAR_MAX)) u_first (
    .day_i    (in_q.first_day),
    .month_i  (in_q.first_month),
    .year_i   (in_q.first_year),
    .valid_o  (first_ok),
    .day_num_o(first_num)
  );

  ddjg_day_num #(.YEAR_MAX(YEAR_MAX)) u_second (
    .day_i    (in_q.second_day),
    .month_i  (in_q.second_month),
    .year_i   (in_q.second_year),
    .valid_o  (second_ok),
    .day_num_o(second_num)
  );

  always_comb begin
    out_d.date_invalid = !(first_ok && second_ok);
    if (first_ok && second_ok) begin
      out_d.day_difference = DiffW'(second_num - first_num);
    end else begin
      out_d.day_difference = '0;
    end
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

@@ sv/ddjg_checker.sv @@
// Port-level checker for the date difference unit and its bind
`include "date_difference_julian_gregorian_unit_defines.svh"

module ddjg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input ddjg_pkg::ddjg_in_t  item_i,
  input logic                done_o,
  input ddjg_pkg::ddjg_out_t result_o
);
  import ddjg_pkg::*;

  logic xfer_in;
  logic same_date;
  logic bad_nonzero;

  assign xfer_in     = start_i && !busy_o;
  assign same_date   = item_i.first_day == item_i.second_day
                       && item_i.first_month == item_i.second_month
                       && item_i.first_year == item_i.second_year;
  assign bad_nonzero = result_o.date_invalid && result_o.day_difference != '0;

  `DDJG_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o, "busy raised")
  `DDJG_ASSERT_IMPLIES(a_result_follows, clk_i, rst_ni, xfer_in, ##2 done_o, "missing result")
  `DDJG_ASSERT_IMPLIES(a_no_spurious, clk_i, rst_ni, done_o, $past(xfer_in, 2), "stray result")
  `DDJG_ASSERT_NEVER(a_invalid_zero, clk_i, rst_ni, done_o && bad_nonzero, "invalid not zero")
  `DDJG_ASSERT_IMPLIES(a_same_date_zero, clk_i, rst_ni, xfer_in && same_date, ##2 (result_o.day_difference == '0), "equal dates")

endmodule

bind date_difference_julian_gregorian_unit ddjg_checker u_ddjg_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .item_i  (item_i),
  .done_o  (done_o),
  .result_o(result_o)
);

@@ sim/testbench.sv @@
// Testbench for the date difference unit: directed table, random date pairs, day count predictor
module testbench;
  import ddjg_pkg::*;

  localparam int REFORM_YEAR     = 1582;
  localparam int REFORM_LENGTH   = 355;
  localparam int YEAR_LIMIT      = 9999;
  localparam int DIRECTED_ROWS   = 25;
  localparam int RANDOM_PAIRS    = 625;
  localparam int QUIET_TAIL      = 100;
  localparam int DRAIN_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT  = 500;

  typedef struct packed {
    logic [DayW-1:0]         d1;
    logic [MonthW-1:0]       m1;
    logic [YearW-1:0]        y1;
    logic [DayW-1:0]         d2;
    logic [MonthW-1:0]       m2;
    logic [YearW-1:0]        y2;
    logic                    typed;
    logic signed [DiffW-1:0] diff;
    logic                    bad;
  } date_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  ddjg_in_t   item_i = '0;
  logic       done_o;
  ddjg_out_t  result_o;

  logic       use_typed = 1'b0;
  ddjg_out_t  typed_result = '0;
  ddjg_out_t  pending_diffs[$];
  int         errors = 0;
  int         pairs_taken = 0;
  int         invalid_seen = 0;
  int         quiet_cycles = 0;

  int month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int days_before[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  date_row_t directed_rows[DIRECTED_ROWS] = '{
    '{1, 1, 1, 1, 1, 1, 1, 0, 0},
    '{0, 1, 2000, 1, 1, 2000, 1, 0, 1},
    '{1, 0, 2000, 1, 1, 2000, 1, 0, 1},
    '{1, 13, 2000, 1, 1, 2000, 1, 0, 1},
    '{31, 15, 16383, 31, 15, 16383, 1, 0, 1},
    '{1, 1, 0, 1, 1, 1, 1, 0, 1},
    '{1, 1, 1, 1, 1, 10000, 1, 0, 1},
    '{31, 2, 2000, 1, 1, 2000, 1, 0, 1},
    '{5, 10, 1582, 1, 1, 1582, 1, 0, 1},
    '{1, 1, 1582, 14, 10, 1582, 1, 0, 1},
    '{4, 10, 1582, 15, 10, 1582, 1, 1, 0},
    '{15, 10, 1582, 4, 10, 1582, 1, -1, 0},
    '{29, 2, 1500, 1, 3, 1500, 1, 1, 0},
    '{29, 2, 1582, 1, 1, 1583, 1, 0, 1},
    '{29, 2, 1700, 1, 1, 1700, 1, 0, 1},
    '{29, 2, 2000, 1, 3, 2000, 1, 1, 0},
    '{1, 1, 1, 31, 12, 9999, 0, 0, 0},
    '{31, 12, 9999, 1, 1, 1, 0, 0, 0},
    '{1, 1, 2000, 2, 1, 2000, 1, 1, 0},
    '{31, 1, 2023, 1, 2, 2023, 1, 1, 0},
    '{31, 4, 2023, 1, 5, 2023, 1, 0, 1},
    '{1, 1, 1581, 1, 1, 1583, 0, 0, 0},
    '{31, 12, 1582, 1, 1, 1583, 1, 1, 0},
    '{1, 1, 2024, 0, 1, 2024, 1, 0, 1},
    '{1, 1, 1600, 1, 1, 1601, 0, 0, 0}
  };

  date_difference_julian_gregorian_unit #(
    .YEAR_MAX(YEAR_LIMIT)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit leap_year(input int y);
    if (y < REFORM_YEAR) return (y % 4) == 0;
    if (y == REFORM_YEAR) return 1'b0;
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int days_in(input int m, input int y);
    return month_days[m-1] + ((m == 2 && leap_year(y)) ? 1 : 0);
  endfunction

  function automatic bit real_date(input int d, input int m, input int y);
    if (m < 1 || m > 12 || y < 1 || y > YEAR_LIMIT) return 1'b0;
    if (d < 1 || d > days_in(m, y)) return 1'b0;
    if (y == REFORM_YEAR && m == 10 && d > 4 && d < 15) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int gregorian_leaps(input int n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic int day_count(input int d, input int m, input int y);
    int n;
    if (y <= REFORM_YEAR) begin
      n = (y - 1) * 365 + (y - 1) / 4;
    end else begin
      n = (REFORM_YEAR - 1) * 365 + (REFORM_YEAR - 1) / 4 + REFORM_LENGTH;
      n += (y - REFORM_YEAR - 1) * 365;
      n += gregorian_leaps(y - 1) - gregorian_leaps(REFORM_YEAR);
    end
    n += days_before[m-1] + d;
    if (m > 2 && leap_year(y)) n += 1;
    if (y == REFORM_YEAR && (m > 10 || (m == 10 && d > 14))) n -= 10;
    return n;
  endfunction

  function automatic ddjg_out_t predict_difference(input ddjg_in_t p);
    ddjg_out_t r;
    int span;
    r = '0;
    if (!real_date(p.first_day, p.first_month, p.first_year) ||
        !real_date(p.second_day, p.second_month, p.second_year)) begin
      r.date_invalid = 1'b1;
    end else begin
      span = day_count(p.second_day, p.second_month, p.second_year) -
             day_count(p.first_day, p.first_month, p.first_year);
      r.day_difference = DiffW'(span);
    end
    return r;
  endfunction

  task automatic pick_date(output logic [DayW-1:0] d, output logic [MonthW-1:0] m,
                           output logic [YearW-1:0] y);
    int yy;
    int mm;
    int len;
    case ($urandom_range(0, 5))
      0: yy = $urandom_range(1, YEAR_LIMIT);
      1: yy = $urandom_range(REFORM_YEAR - 12, REFORM_YEAR + 12);
      2: yy = $urandom_range(1, 12);
      3: yy = $urandom_range(YEAR_LIMIT - 12, YEAR_LIMIT);
      4: yy = $urandom_range(1, YEAR_LIMIT / 100) * 100;
      default: yy = REFORM_YEAR;
    endcase
    mm = $urandom_range(1, 12);
    if (yy == REFORM_YEAR && $urandom_range(0, 1) == 0) mm = 10;
    len = days_in(mm, yy);
    case ($urandom_range(0, 3))
      0: d = DayW'(1);
      1: d = DayW'(len);
      default: d = DayW'($urandom_range(1, len));
    endcase
    m = MonthW'(mm);
    y = YearW'(yy);
  endtask

  task automatic send_pair(input ddjg_in_t pair, input bit typed, input ddjg_out_t known,
                           input bit may_idle);
    start_i      <= 1'b1;
    item_i       <= pair;
    use_typed    <= typed;
    typed_result <= known;
    do @(posedge clk_i); while (busy_o);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    do @(negedge clk_i); while (pending_diffs.size() != 0);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    ddjg_out_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        pending_diffs.push_back(use_typed ? typed_result : predict_difference(item_i));
        pairs_taken++;
      end
      if (done_o) begin
        if (result_o.date_invalid) invalid_seen++;
        if (pending_diffs.size() == 0) begin
          $error("result transfer with no date pair outstanding");
          errors++;
        end else begin
          want = pending_diffs.pop_front();
          if (result_o.day_difference !== want.day_difference) begin
            $error("day_difference: expected %0d, got %0d",
                   want.day_difference, result_o.day_difference);
            errors++;
          end
          if (result_o.date_invalid !== want.date_invalid) begin
            $error("date_invalid: expected %0b, got %0b",
                   want.date_invalid, result_o.date_invalid);
            errors++;
          end
        end
      end
      if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    ddjg_in_t  pair;
    ddjg_out_t known;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      pair = '{directed_rows[i].d1, directed_rows[i].m1, directed_rows[i].y1,
               directed_rows[i].d2, directed_rows[i].m2, directed_rows[i].y2};
      known = '{directed_rows[i].diff, directed_rows[i].bad};
      send_pair(pair, directed_rows[i].typed, known, 1'b1);
    end

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      pick_date(pair.first_day, pair.first_month, pair.first_year);
      pick_date(pair.second_day, pair.second_month, pair.second_year);
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 2) != 1) begin
          pair.first_day   = DayW'($urandom);
          pair.first_month = MonthW'($urandom);
          pair.first_year  = YearW'($urandom);
        end
        if ($urandom_range(0, 2) != 0) begin
          pair.second_day   = DayW'($urandom);
          pair.second_month = MonthW'($urandom);
          pair.second_year  = YearW'($urandom);
        end
      end
      if (i == RANDOM_PAIRS / 2) begin
        start_i <= 1'b0;
        drain_results();
      end
      send_pair(pair, 1'b0, '0, i < RANDOM_PAIRS - QUIET_TAIL);
    end

    start_i <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_diffs.size() != 0) begin
      $error("%0d date pairs never produced a result", pending_diffs.size());
      errors++;
    end
    $display("Covered %0d date pairs (Julian, Gregorian and reform-year dates), %0d invalid",
             pairs_taken, invalid_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ date_difference_julian_gregorian_unit.f @@
+incdir+sv
sv/ddjg_pkg.sv
sv/ddjg_day_num.sv
sv/date_difference_julian_gregorian_unit.sv
sv/ddjg_checker.sv
sim/testbench.sv
